// ===== rtl/lpec_pkg.sv =====
`default_nettype none
// ============================================================================
// lpec_pkg
// Shared widths, constants and arithmetic helpers for the log-polynomial
// efficiency curve pipeline.
// ============================================================================
package lpec_pkg;

    localparam int ENERGY_W      = 24;
    localparam int NORM_W        = 32;
    localparam int COEFF_W       = 32;
    localparam int EFF_W         = 32;
    localparam int MAX_TERMS     = 6;
    localparam int NUM_TERMS_DEF = 6;
    localparam int FRAC_W        = 24;
    localparam int EXP_W         = 5;
    localparam int LOG_W         = 29;
    localparam int MANT_W        = 31;
    localparam int PW_W          = 48;
    localparam int TAYLOR_N      = 13;
    localparam int TERM_W        = 33;
    localparam int QUOT_W        = 64;
    localparam int CFG_IDX_W     = 3;
    localparam int USER_W        = 2;

    localparam logic [31:0]       LN2_Q32        = 32'hB17217F8;
    localparam logic [30:0]       LOG2E_Q30      = 31'd1549082005;
    localparam logic [23:0]       REF_ENERGY_RST = 24'd16000;
    localparam logic [31:0]       NORM_RST       = 32'h0100_0000;
    localparam logic signed [63:0] F_LIM         = 64'sh4000_0000;

    // Integer part of y is held with an offset of 128.
    localparam logic [7:0] K_SAT   = 8'd144;
    localparam logic [7:0] K_UNITY = 8'd143;
    localparam logic [7:0] K_ZERO  = 8'd79;

    // floor(2^32 / n) for the Taylor term division.
    localparam logic [32:0] RECIP [1:TAYLOR_N] = '{
        33'd4294967296, 33'd2147483648, 33'd1431655765, 33'd1073741824,
        33'd858993459,  33'd715827882,  33'd613566756,  33'd536870912,
        33'd477218588,  33'd429496729,  33'd390451572,  33'd357913941,
        33'd330382099
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REF_ENERGY = 3'd0,
        CFG_NORM       = 3'd1,
        CFG_COEFF0     = 3'd2,
        CFG_COEFF1     = 3'd3,
        CFG_COEFF2     = 3'd4,
        CFG_COEFF3     = 3'd5,
        CFG_COEFF4     = 3'd6,
        CFG_COEFF5     = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [MANT_W-1:0] mant;
        logic [FRAC_W-1:0] frac;
    } log_step_t;

    function automatic logic [EXP_W-1:0] msb_index(input logic [ENERGY_W-1:0] v);
        logic [EXP_W-1:0] p;
        p = '0;
        for (int i = 1; i < ENERGY_W; i++) begin
            if (v[i]) begin
                p = EXP_W'(i);
            end
        end
        return p;
    endfunction

    function automatic logic [MANT_W-1:0] mant_init(input logic [ENERGY_W-1:0] v,
                                                    input logic [EXP_W-1:0] p);
        return MANT_W'(v) << (EXP_W'(30) - p);
    endfunction

    function automatic log_step_t log_step(input log_step_t a);
        logic [61:0] sq;
        logic [31:0] m2;
        log_step_t   o;
        sq     = 62'(a.mant) * 62'(a.mant);
        m2     = sq[61:30];
        o.frac = {a.frac[FRAC_W-2:0], m2[31]};
        o.mant = m2[31] ? m2[31:1] : m2[30:0];
        return o;
    endfunction

    function automatic logic [63:0] mul_q24(input logic [PW_W-1:0] a,
                                            input logic [31:0] b);
        logic [55:0] hi;
        logic [56:0] lo;
        hi = 56'(a[47:24]) * 56'(b);
        lo = 57'(a[23:0]) * 57'(b) + 57'h80_0000;
        return 64'(hi) + 64'(lo[56:24]);
    endfunction

    function automatic logic [31:0] abs32(input logic [31:0] c);
        return c[31] ? (32'd0 - c) : c;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/log_poly_efficiency_curve.sv =====
`default_nettype none
// ============================================================================
// log_poly_efficiency_curve
// Pipelined evaluation of exp(c0 + sum ci*ln(E/E0)^i) / normalisation in
// fixed point, one energy word per cycle while s_tready is high.
// ============================================================================
//
// Channel   Direction  Payload
// s_        in         tdata[23:0] energy
// m_        out        tdata[31:0] efficiency; tuser[0] saturated, tuser[1] invalid
// cfg_      in         addr = register index, wdata = register value
//
// A word accepted on s_ passes the 24 log2 squaring stages, the polynomial,
// exp and Taylor stages and the 64-stage restoring divider on its way to m_.
// One word enters per cycle while m_ takes words; a two-word output buffer
// lets s_ accept while a result waits.
// After reset and after each write to reference_energy, s_tready stays low
// while log2 of the reference energy is computed.
// Reset is synchronous and active low.
//
module log_poly_efficiency_curve
    import lpec_pkg::*;
#(
    parameter int NUM_TERMS = NUM_TERMS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [ENERGY_W-1:0]   s_tdata,    // [23:0] energy
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [EFF_W-1:0]      m_tdata,    // [31:0] efficiency
    output logic [USER_W-1:0]     m_tuser,    // [0] saturated, [1] invalid
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [31:0]           cfg_wdata
);

    localparam int NP = NUM_TERMS - 1;

    // Configuration and reference log
    logic [ENERGY_W-1:0]  ref_energy_reg;
    logic [NORM_W-1:0]    norm_reg;
    logic [COEFF_W-1:0]   coeff_reg [0:NUM_TERMS-1];
    logic                 lg_start_reg;
    logic                 lg_busy_reg;
    logic [4:0]           lg_cnt_reg;
    log_step_t            lg_st_reg;
    log_step_t            lg_st_step;
    logic [EXP_W-1:0]     lg_p_reg;
    logic [LOG_W-1:0]     l0_reg;
    logic [ENERGY_W-1:0]  e0_eff;
    logic [EXP_W-1:0]     e0_p;

    // Pipeline
    logic                 en;
    logic [EXP_W-1:0]     in_p;
    log_step_t            sq_st_reg    [0:FRAC_W];
    logic [EXP_W-1:0]     sq_p_reg     [0:FRAC_W];
    logic                 sq_inv_reg   [0:FRAC_W];
    logic                 sq_valid_reg [0:FRAC_W];

    logic [29:0]          d_diff;
    logic [LOG_W-1:0]     d_dmag_reg;
    logic                 d_lneg_reg;
    logic                 d_inv_reg;
    logic                 d_valid_reg;
    logic [60:0]          n_prod;

    logic [PW_W-1:0]      po_pw_reg    [0:NP];
    logic signed [63:0]   po_f_reg     [0:NP];
    logic [LOG_W-1:0]     po_lmag_reg  [0:NP];
    logic                 po_lneg_reg  [0:NP];
    logic                 po_inv_reg   [0:NP];
    logic                 po_valid_reg [0:NP];
    logic [PW_W-1:0]      pm_pw_reg    [0:NP];
    logic signed [63:0]   pm_f_reg     [0:NP];
    logic [LOG_W-1:0]     pm_lmag_reg  [0:NP];
    logic                 pm_lneg_reg  [0:NP];
    logic                 pm_inv_reg   [0:NP];
    logic                 pm_valid_reg [0:NP];
    logic [63:0]          term_prod    [0:NP];
    logic                 term_neg     [0:NP];

    logic signed [63:0]   f_clamp;
    logic [30:0]          c_fmag_reg;
    logic                 c_fneg_reg;
    logic                 c_inv_reg;
    logic                 c_valid_reg;
    logic [61:0]          y_prod;
    logic [31:0]          y_mag_reg;
    logic                 y_neg_reg;
    logic                 y_inv_reg;
    logic                 y_valid_reg;
    logic [31:0]          yu;
    logic [7:0]           k_kk_reg;
    logic [23:0]          k_r_reg;
    logic                 k_inv_reg;
    logic                 k_valid_reg;
    logic [55:0]          x_prod;

    logic [TERM_W-1:0]    tc_term_reg  [0:TAYLOR_N];
    logic [TERM_W-1:0]    tc_sum_reg   [0:TAYLOR_N];
    logic [31:0]          tc_x_reg     [0:TAYLOR_N];
    logic [7:0]           tc_kk_reg    [0:TAYLOR_N];
    logic                 tc_inv_reg   [0:TAYLOR_N];
    logic                 tc_valid_reg [0:TAYLOR_N];
    logic [31:0]          ta_v_reg     [0:TAYLOR_N];
    logic [TERM_W-1:0]    ta_sum_reg   [0:TAYLOR_N];
    logic [31:0]          ta_x_reg     [0:TAYLOR_N];
    logic [7:0]           ta_kk_reg    [0:TAYLOR_N];
    logic                 ta_inv_reg   [0:TAYLOR_N];
    logic                 ta_valid_reg [0:TAYLOR_N];
    logic [31:0]          tb_v_reg     [0:TAYLOR_N];
    logic [31:0]          tb_qe_reg    [0:TAYLOR_N];
    logic [TERM_W-1:0]    tb_sum_reg   [0:TAYLOR_N];
    logic [31:0]          tb_x_reg     [0:TAYLOR_N];
    logic [7:0]           tb_kk_reg    [0:TAYLOR_N];
    logic                 tb_inv_reg   [0:TAYLOR_N];
    logic                 tb_valid_reg [0:TAYLOR_N];
    logic [31:0]          tay_rem      [0:TAYLOR_N];
    logic [31:0]          tay_q        [0:TAYLOR_N];

    logic [31:0]          dv_rem_reg   [0:QUOT_W];
    logic [QUOT_W-1:0]    dv_dq_reg    [0:QUOT_W];
    logic [7:0]           dv_kk_reg    [0:QUOT_W];
    logic                 dv_inv_reg   [0:QUOT_W];
    logic                 dv_valid_reg [0:QUOT_W];
    logic [32:0]          dv_t         [0:QUOT_W];
    logic                 dv_ge        [0:QUOT_W];

    // Result and output buffer
    logic [QUOT_W-1:0]    fin_q;
    logic [7:0]           fin_kk;
    logic [7:0]           fin_sh;
    logic [64:0]          fin_shifted;
    logic [64:0]          fin_rounded;
    logic [64:0]          fin_wide;
    logic                 fin_sat;
    logic [EFF_W-1:0]     fin_eff;
    logic                 push;
    logic                 pop;
    logic                 head_valid_reg;
    logic [EFF_W-1:0]     head_data_reg;
    logic [USER_W-1:0]    head_user_reg;
    logic                 skid_valid_reg;
    logic [EFF_W-1:0]     skid_data_reg;
    logic [USER_W-1:0]    skid_user_reg;

    assign cfg_ready = 1'b1;
    assign en        = !skid_valid_reg;
    assign s_tready  = en && !lg_start_reg && !lg_busy_reg;
    assign m_tvalid  = head_valid_reg;
    assign m_tdata   = head_data_reg;
    assign m_tuser   = head_user_reg;

    // ------------------------------------------------------------------
    // Configuration registers and log2 of the reference energy
    // ------------------------------------------------------------------
    assign e0_eff     = (ref_energy_reg == '0) ? ENERGY_W'(1) : ref_energy_reg;
    assign e0_p       = msb_index(e0_eff);
    assign lg_st_step = log_step(lg_st_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_energy_reg <= REF_ENERGY_RST;
            norm_reg       <= NORM_RST;
            for (int i = 0; i < NUM_TERMS; i++) begin
                coeff_reg[i] <= '0;
            end
            lg_start_reg   <= 1'b1;
            lg_busy_reg    <= 1'b0;
            lg_cnt_reg     <= '0;
        end else begin
            if (lg_start_reg) begin
                lg_start_reg <= 1'b0;
                lg_busy_reg  <= 1'b1;
                lg_cnt_reg   <= '0;
            end else if (lg_busy_reg) begin
                lg_cnt_reg <= lg_cnt_reg + 5'd1;
                if (lg_cnt_reg == 5'(FRAC_W - 1)) begin
                    lg_busy_reg <= 1'b0;
                end
            end
            if (cfg_valid) begin
                if (cfg_addr == CFG_REF_ENERGY) begin
                    ref_energy_reg <= cfg_wdata[ENERGY_W-1:0];
                    lg_start_reg   <= 1'b1;
                end else if (cfg_addr == CFG_NORM) begin
                    norm_reg <= cfg_wdata;
                end
                for (int i = 0; i < NUM_TERMS; i++) begin
                    if (cfg_addr == CFG_IDX_W'(int'(CFG_COEFF0) + i)) begin
                        coeff_reg[i] <= cfg_wdata;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (lg_start_reg) begin
            lg_p_reg       <= e0_p;
            lg_st_reg.mant <= mant_init(e0_eff, e0_p);
            lg_st_reg.frac <= '0;
        end else if (lg_busy_reg) begin
            lg_st_reg <= lg_st_step;
            if (lg_cnt_reg == 5'(FRAC_W - 1)) begin
                l0_reg <= {lg_p_reg, lg_st_step.frac};
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage arithmetic
    // ------------------------------------------------------------------
    assign in_p   = msb_index(s_tdata);
    assign d_diff = {1'b0, sq_p_reg[FRAC_W], sq_st_reg[FRAC_W].frac} - {1'b0, l0_reg};
    assign n_prod = 61'(d_dmag_reg) * 61'(LN2_Q32) + 61'h8000_0000;

    always_comb begin
        term_prod[0] = '0;
        term_neg[0]  = 1'b0;
        for (int i = 1; i <= NP; i++) begin
            term_prod[i] = mul_q24(pm_pw_reg[i], abs32(coeff_reg[i]));
            term_neg[i]  = coeff_reg[i][31] ^ (pm_lneg_reg[i] & (i % 2 == 1));
        end
    end

    always_comb begin
        f_clamp = po_f_reg[NP];
        if (po_f_reg[NP] > F_LIM) begin
            f_clamp = F_LIM;
        end else if (po_f_reg[NP] < -F_LIM) begin
            f_clamp = -F_LIM;
        end
    end

    assign y_prod = 62'(c_fmag_reg) * 62'(LOG2E_Q30) + 62'h2000_0000;
    assign yu     = y_neg_reg ? (32'h8000_0000 - y_mag_reg) : (32'h8000_0000 + y_mag_reg);
    assign x_prod = 56'(k_r_reg) * 56'(LN2_Q32);

    always_comb begin
        tay_rem[0] = '0;
        tay_q[0]   = '0;
        for (int n = 1; n <= TAYLOR_N; n++) begin
            tay_rem[n] = tb_v_reg[n] - 32'(tb_qe_reg[n] * 32'(n));
            tay_q[n]   = tb_qe_reg[n] + {31'b0, tay_rem[n] >= 32'(n)};
        end
    end

    always_comb begin
        for (int j = 0; j <= QUOT_W; j++) begin
            dv_t[j]  = {dv_rem_reg[j], dv_dq_reg[j][QUOT_W-1]};
            dv_ge[j] = dv_t[j] >= {1'b0, norm_reg};
        end
    end

    // ------------------------------------------------------------------
    // Pipeline payload
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (en) begin
            sq_p_reg[0]        <= in_p;
            sq_st_reg[0].mant  <= mant_init(s_tdata, in_p);
            sq_st_reg[0].frac  <= '0;
            sq_inv_reg[0]      <= (s_tdata == '0);
            for (int j = 1; j <= FRAC_W; j++) begin
                sq_st_reg[j]  <= log_step(sq_st_reg[j-1]);
                sq_p_reg[j]   <= sq_p_reg[j-1];
                sq_inv_reg[j] <= sq_inv_reg[j-1];
            end

            d_lneg_reg <= d_diff[29];
            d_dmag_reg <= LOG_W'(d_diff[29] ? (30'd0 - d_diff) : d_diff);
            d_inv_reg  <= sq_inv_reg[FRAC_W];

            po_pw_reg[0]   <= PW_W'(n_prod[60:32]);
            po_lmag_reg[0] <= n_prod[60:32];
            po_lneg_reg[0] <= d_lneg_reg;
            po_inv_reg[0]  <= d_inv_reg;
            po_f_reg[0]    <= {{32{coeff_reg[0][31]}}, coeff_reg[0]};
            for (int i = 1; i <= NP; i++) begin
                pm_pw_reg[i]   <= (i == 1) ? PW_W'(po_lmag_reg[i-1])
                                           : PW_W'(mul_q24(po_pw_reg[i-1],
                                                           32'(po_lmag_reg[i-1])));
                pm_f_reg[i]    <= po_f_reg[i-1];
                pm_lmag_reg[i] <= po_lmag_reg[i-1];
                pm_lneg_reg[i] <= po_lneg_reg[i-1];
                pm_inv_reg[i]  <= po_inv_reg[i-1];
                po_pw_reg[i]   <= pm_pw_reg[i];
                po_f_reg[i]    <= term_neg[i] ? (pm_f_reg[i] - signed'(term_prod[i]))
                                              : (pm_f_reg[i] + signed'(term_prod[i]));
                po_lmag_reg[i] <= pm_lmag_reg[i];
                po_lneg_reg[i] <= pm_lneg_reg[i];
                po_inv_reg[i]  <= pm_inv_reg[i];
            end

            c_fneg_reg <= f_clamp[63];
            c_fmag_reg <= 31'(f_clamp[63] ? (64'sd0 - f_clamp) : f_clamp);
            c_inv_reg  <= po_inv_reg[NP];

            y_mag_reg <= y_prod[61:30];
            y_neg_reg <= c_fneg_reg;
            y_inv_reg <= c_inv_reg;

            k_kk_reg  <= yu[31:24];
            k_r_reg   <= yu[23:0];
            k_inv_reg <= y_inv_reg;

            tc_term_reg[0] <= TERM_W'(33'h1_0000_0000);
            tc_sum_reg[0]  <= TERM_W'(33'h1_0000_0000);
            tc_x_reg[0]    <= x_prod[55:24];
            tc_kk_reg[0]   <= k_kk_reg;
            tc_inv_reg[0]  <= k_inv_reg;
            for (int n = 1; n <= TAYLOR_N; n++) begin
                ta_v_reg[n]    <= 32'((65'(tc_term_reg[n-1]) * 65'(tc_x_reg[n-1])) >> 32);
                ta_sum_reg[n]  <= tc_sum_reg[n-1];
                ta_x_reg[n]    <= tc_x_reg[n-1];
                ta_kk_reg[n]   <= tc_kk_reg[n-1];
                ta_inv_reg[n]  <= tc_inv_reg[n-1];
                tb_v_reg[n]    <= ta_v_reg[n];
                tb_qe_reg[n]   <= 32'((65'(ta_v_reg[n]) * 65'(RECIP[n])) >> 32);
                tb_sum_reg[n]  <= ta_sum_reg[n];
                tb_x_reg[n]    <= ta_x_reg[n];
                tb_kk_reg[n]   <= ta_kk_reg[n];
                tb_inv_reg[n]  <= ta_inv_reg[n];
                tc_term_reg[n] <= TERM_W'(tay_q[n]);
                tc_sum_reg[n]  <= tb_sum_reg[n] + TERM_W'(tay_q[n]);
                tc_x_reg[n]    <= tb_x_reg[n];
                tc_kk_reg[n]   <= tb_kk_reg[n];
                tc_inv_reg[n]  <= tb_inv_reg[n];
            end

            dv_rem_reg[0] <= '0;
            dv_dq_reg[0]  <= {tc_sum_reg[TAYLOR_N], 31'b0};
            dv_kk_reg[0]  <= tc_kk_reg[TAYLOR_N];
            dv_inv_reg[0] <= tc_inv_reg[TAYLOR_N];
            for (int j = 1; j <= QUOT_W; j++) begin
                dv_rem_reg[j] <= dv_ge[j-1] ? 32'(dv_t[j-1] - {1'b0, norm_reg})
                                            : dv_t[j-1][31:0];
                dv_dq_reg[j]  <= {dv_dq_reg[j-1][QUOT_W-2:0], dv_ge[j-1]};
                dv_kk_reg[j]  <= dv_kk_reg[j-1];
                dv_inv_reg[j] <= dv_inv_reg[j-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Pipeline valid bits
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j <= FRAC_W; j++) begin
                sq_valid_reg[j] <= 1'b0;
            end
            d_valid_reg <= 1'b0;
            for (int i = 0; i <= NP; i++) begin
                po_valid_reg[i] <= 1'b0;
                pm_valid_reg[i] <= 1'b0;
            end
            c_valid_reg <= 1'b0;
            y_valid_reg <= 1'b0;
            k_valid_reg <= 1'b0;
            for (int n = 0; n <= TAYLOR_N; n++) begin
                tc_valid_reg[n] <= 1'b0;
                ta_valid_reg[n] <= 1'b0;
                tb_valid_reg[n] <= 1'b0;
            end
            for (int j = 0; j <= QUOT_W; j++) begin
                dv_valid_reg[j] <= 1'b0;
            end
        end else if (en) begin
            sq_valid_reg[0] <= s_tvalid && s_tready;
            for (int j = 1; j <= FRAC_W; j++) begin
                sq_valid_reg[j] <= sq_valid_reg[j-1];
            end
            d_valid_reg     <= sq_valid_reg[FRAC_W];
            po_valid_reg[0] <= d_valid_reg;
            for (int i = 1; i <= NP; i++) begin
                pm_valid_reg[i] <= po_valid_reg[i-1];
                po_valid_reg[i] <= pm_valid_reg[i];
            end
            c_valid_reg     <= po_valid_reg[NP];
            y_valid_reg     <= c_valid_reg;
            k_valid_reg     <= y_valid_reg;
            tc_valid_reg[0] <= k_valid_reg;
            for (int n = 1; n <= TAYLOR_N; n++) begin
                ta_valid_reg[n] <= tc_valid_reg[n-1];
                tb_valid_reg[n] <= ta_valid_reg[n];
                tc_valid_reg[n] <= tb_valid_reg[n];
            end
            dv_valid_reg[0] <= tc_valid_reg[TAYLOR_N];
            for (int j = 1; j <= QUOT_W; j++) begin
                dv_valid_reg[j] <= dv_valid_reg[j-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Scaling, rounding and saturation
    // ------------------------------------------------------------------
    always_comb begin
        fin_q       = dv_dq_reg[QUOT_W];
        fin_kk      = dv_kk_reg[QUOT_W];
        fin_sh      = K_UNITY - fin_kk;
        fin_shifted = 65'(fin_q >> 6'(fin_sh - 8'd1));
        fin_rounded = (fin_shifted + 65'd1) >> 1;
        fin_wide    = '0;
        fin_sat     = 1'b0;
        if (dv_inv_reg[QUOT_W]) begin
            fin_wide = '0;
        end else if (norm_reg == '0 || fin_kk >= K_SAT) begin
            fin_sat = 1'b1;
        end else if (fin_kk < K_ZERO) begin
            fin_wide = '0;
        end else if (fin_kk == K_UNITY) begin
            fin_wide = 65'(fin_q);
        end else begin
            fin_wide = fin_rounded;
        end
        if (fin_wide > 65'(32'hFFFF_FFFF)) begin
            fin_sat = 1'b1;
        end
        fin_eff = fin_sat ? '1 : fin_wide[EFF_W-1:0];
    end

    // ------------------------------------------------------------------
    // Two-word output buffer
    // ------------------------------------------------------------------
    assign push = en && dv_valid_reg[QUOT_W];
    assign pop  = head_valid_reg && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (!head_valid_reg || pop) begin
                if (skid_valid_reg) begin
                    head_valid_reg <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end else begin
                    head_valid_reg <= push;
                end
            end else if (push) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!head_valid_reg || pop) begin
            if (skid_valid_reg) begin
                head_data_reg <= skid_data_reg;
                head_user_reg <= skid_user_reg;
            end else begin
                head_data_reg <= fin_eff;
                head_user_reg <= {dv_inv_reg[QUOT_W], fin_sat};
            end
        end else if (push) begin
            skid_data_reg <= fin_eff;
            skid_user_reg <= {dv_inv_reg[QUOT_W], fin_sat};
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> (m_tdata == '0) && !m_tuser[0])
        else $error("Invalid word carries a nonzero result or a saturation flag.");

    a_sat_ones: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '1)
        else $error("Saturated word is not all ones.");

    a_ref_log_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (lg_start_reg || lg_busy_reg) |-> !s_tready)
        else $error("Input accepted while the reference log is being computed.");

    a_skid_order: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> head_valid_reg)
        else $error("Skid word held while the output register is empty.");

endmodule
`default_nettype wire
